// File: hw/rtl/ima_pkg.sv
// ima_pkg: shared types and constants of the interferometric map accumulator.
// No dependencies; compile first.
package ima_pkg;

    localparam int DEF_CORR_DEPTH = 4096;
    localparam int DEF_MAP_BINS   = 131072;

    localparam int SAMPLE_W = 16;
    localparam int VAL_W    = 18;   // interpolated value, Q1.15 plus headroom
    localparam int ADD_W    = 36;   // value times weight
    localparam int SUM_W    = 48;

    localparam logic [SUM_W-1:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 48'h8000_0000_0000;

    localparam logic [31:0] RECIP_RESET = 32'h0100_0000;
    localparam logic [12:0] NPTS_RESET  = 13'd4096;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ACC  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_START_TIME = 2'd0,
        CFG_RECIP      = 2'd1,
        CFG_NUM_POINTS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] start_time;
        logic        [31:0] recip_spacing;
        logic        [12:0] num_points;
    } cfg_t;

    typedef struct packed {
        logic        [1:0]  req_type;
        logic        [11:0] sample_index;
        logic signed [15:0] sample_value;
        logic        [16:0] map_bin;
        logic signed [31:0] delay;
        logic        [16:0] pair_weight;
    } item_t;

endpackage

// File: hw/rtl/ima_if.sv
// Valid/ready channel interfaces of the interferometric map accumulator.
// Standalone; no package dependency.
interface ima_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  req_type;
    logic        [11:0] sample_index;
    logic signed [15:0] sample_value;
    logic        [16:0] map_bin;
    logic signed [31:0] delay;
    logic        [16:0] pair_weight;

    modport source (
        output valid, req_type, sample_index, sample_value, map_bin, delay, pair_weight,
        input  ready
    );
    modport sink (
        input  valid, req_type, sample_index, sample_value, map_bin, delay, pair_weight,
        output ready
    );
endinterface

interface ima_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] map_value;
    logic        [16:0] bin_out;

    modport source (output valid, map_value, bin_out, input ready);
    modport sink (input valid, map_value, bin_out, output ready);
endinterface

// File: hw/rtl/interferometric_map_accumulator.sv
// Interferometric map accumulator: top level with map-sum read-modify-write.
// Depends on ima_pkg, ima_if, ima_ram and ima_interp.
//
//  channel   dir  handshake          contents
//  item      in   valid/ready        req_type, sample_index, sample_value, map_bin,
//                                    delay, pair_weight
//  result    out  valid/ready        map_value, bin_out (one per readout)
//  cfg       in   cfg_wr_en          cfg_index, cfg_data (no read-back)
//
// One transaction per cycle while item.ready is high; readouts leave from stage 7.
// The map store is one single-port-write RAM read one stage ahead of write-back;
// back-to-back updates of one bin are served from a one-entry forwarding register.
// After reset a clearing pass zeroes all MAP_BINS map entries (131072 by default),
// during which item.ready is low.
// The pipeline stalls only when a readout reaches the last stage while the output
// register is full and not being taken.
module interferometric_map_accumulator
    import ima_pkg::*;
#(
    parameter int CORR_DEPTH = DEF_CORR_DEPTH,
    parameter int MAP_BINS   = DEF_MAP_BINS
) (
    input  logic        clk,
    input  logic        rst_n,
    ima_in_if.sink      item,
    ima_out_if.source   result,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int BIN_AW = $clog2(MAP_BINS);
    localparam int EXT_W  = SUM_W + 1;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    typedef struct packed {
        op_t         op;
        logic        bin_ok;
        logic [16:0] bin;
        logic [16:0] weight;
    } ctl_t;

    cfg_t                      cfg_reg;
    state_t                    state_reg;
    state_t                    state_next;
    logic [BIN_AW-1:0]         clr_addr_reg;
    logic [BIN_AW-1:0]         clr_addr_next;
    logic                      clearing;

    logic                      adv;
    logic                      in_take;
    logic [7:1]                vld_reg;
    item_t                     item_reg;
    ctl_t                      ctl1;
    ctl_t                      ctl_reg [2:7];
    logic                      ld_en;
    logic signed [VAL_W-1:0]   val6;
    logic signed [ADD_W-1:0]   add_reg;

    logic [BIN_AW-1:0]         w_addr;
    logic [SUM_W-1:0]          map_rdata;
    logic                      fwd_vld_reg;
    logic [BIN_AW-1:0]         fwd_addr_reg;
    logic [SUM_W-1:0]          fwd_val_reg;
    logic                      fwd_hit;
    logic signed [SUM_W-1:0]   cur;
    logic signed [EXT_W-1:0]   sum;
    logic [SUM_W-1:0]          sat;
    logic                      item_we;
    logic                      map_we;
    logic [BIN_AW-1:0]         map_waddr;
    logic [SUM_W-1:0]          map_wdata;
    logic                      rd_at_w;

    logic                      out_vld_reg;
    logic [SUM_W-1:0]          out_val_reg;
    logic [16:0]               out_bin_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_time    <= '0;
            cfg_reg.recip_spacing <= RECIP_RESET;
            cfg_reg.num_points    <= NPTS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_TIME: cfg_reg.start_time    <= cfg_data;
                CFG_RECIP:      cfg_reg.recip_spacing <= cfg_data;
                CFG_NUM_POINTS: cfg_reg.num_points    <= cfg_data[12:0];
                default:        ;
            endcase
        end
    end

    // clearing pass over the map after reset
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == BIN_AW'(MAP_BINS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:  ;
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign clearing = (state_reg == ST_CLEAR);

    // pipeline control
    assign rd_at_w    = vld_reg[7] && (ctl_reg[7].op == OP_READ);
    assign adv        = !(rd_at_w && out_vld_reg && !result.ready);
    assign item.ready = adv && !clearing;
    assign in_take    = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[6:1], in_take};
        end
    end

    always_comb
    begin
        ctl1.op     = op_t'(item_reg.req_type);
        ctl1.bin_ok = 32'(item_reg.map_bin) < 32'(MAP_BINS);
        ctl1.bin    = item_reg.map_bin;
        ctl1.weight = item_reg.pair_weight;
        ld_en = vld_reg[1] && (ctl1.op == OP_LOAD)
                && (32'(item_reg.sample_index) < 32'(CORR_DEPTH));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg.req_type     <= item.req_type;
            item_reg.sample_index <= item.sample_index;
            item_reg.sample_value <= item.sample_value;
            item_reg.map_bin      <= item.map_bin;
            item_reg.delay        <= item.delay;
            item_reg.pair_weight  <= item.pair_weight;
            ctl_reg[2] <= ctl1;
            for (int k = 3; k <= 7; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
            add_reg <= val6 * $signed({1'b0, ctl_reg[6].weight});
        end
    end

    ima_interp #(
        .CORR_DEPTH (CORR_DEPTH)
    ) u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .ld_en (ld_en),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .val   (val6)
    );

    // map store: read at stage 6, write back at stage 7
    ima_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAP_BINS)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (adv),
        .raddr (BIN_AW'(ctl_reg[6].bin)),
        .rdata (map_rdata)
    );

    always_comb
    begin
        w_addr  = BIN_AW'(ctl_reg[7].bin);
        fwd_hit = fwd_vld_reg && (fwd_addr_reg == w_addr);
        cur     = fwd_hit ? fwd_val_reg : map_rdata;
        sum     = EXT_W'(cur) + EXT_W'(add_reg);
        if (sum[EXT_W-1] != sum[EXT_W-2])
        begin
            sat = sum[EXT_W-1] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sat = sum[SUM_W-1:0];
        end
        item_we = adv && vld_reg[7] && ctl_reg[7].bin_ok
                  && ((ctl_reg[7].op == OP_ACC) || (ctl_reg[7].op == OP_READ));
        if (clearing)
        begin
            map_we    = 1'b1;
            map_waddr = clr_addr_reg;
            map_wdata = '0;
        end
        else
        begin
            map_we    = item_we;
            map_waddr = w_addr;
            map_wdata = (ctl_reg[7].op == OP_READ) ? '0 : sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vld_reg <= 1'b0;
        end
        else if (map_we)
        begin
            fwd_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            fwd_addr_reg <= map_waddr;
            fwd_val_reg  <= map_wdata;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv && rd_at_w)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && rd_at_w)
        begin
            out_val_reg <= ctl_reg[7].bin_ok ? cur : '0;
            out_bin_reg <= ctl_reg[7].bin;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.map_value = out_val_reg;
    assign result.bin_out   = out_bin_reg;

    // checks
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (vld_reg == '0))
        else $error("transaction in flight during map clearing");

    a_clear_no_item_write: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !item_we)
        else $error("item write to map during clearing");

    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |=> (state_reg == ST_RUN)
                     || (clr_addr_reg == BIN_AW'($past(clr_addr_reg) + 1'b1)))
        else $error("clearing pass skipped an entry");

    a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        map_we |=> fwd_vld_reg && (fwd_addr_reg == $past(map_waddr))
                   && (fwd_val_reg == $past(map_wdata)))
        else $error("forwarding register missed a map write");

    a_readout_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_we && (ctl_reg[7].op == OP_READ)) |=> (fwd_val_reg == '0))
        else $error("readout did not clear the bin");

endmodule

// File: hw/rtl/ima_ram.sv
// ima_ram: generic single-write, single-read RAM with registered read data.
// Read of an address written in the same cycle returns the old contents.
module ima_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/ima_interp.sv
// ima_interp: delay to sample position, correlation store and linear interpolation.
// Depends on ima_pkg and ima_ram. Five stages, all advancing on adv.
module ima_interp
    import ima_pkg::*;
#(
    parameter int CORR_DEPTH = DEF_CORR_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    ld_en,
    input  item_t                   item,
    input  cfg_t                    cfg,
    output logic signed [VAL_W-1:0] val
);

    localparam int CAW = $clog2(CORR_DEPTH);

    // stage 2: offset magnitude
    logic signed [32:0]         diff;
    logic        [32:0]         mag_next;
    logic                       neg2_reg;
    logic        [32:0]         mag2_reg;
    logic                       ld2_reg;
    logic        [11:0]         sidx2_reg;
    logic        [SAMPLE_W-1:0] sval2_reg;

    // stage 3: partial products
    logic        [48:0]         hi3_reg;
    logic        [48:0]         lo3_reg;
    logic                       neg3_reg;
    logic                       ld3_reg;
    logic        [11:0]         sidx3_reg;
    logic        [SAMPLE_W-1:0] sval3_reg;
    logic        [49:0]         pos;
    logic        [25:0]         idx;
    logic        [31:0]         idx32;
    logic        [31:0]         npts32;
    logic        [31:0]         depth32;
    logic        [31:0]         n32;
    logic                       zero_next;
    logic                       last_next;
    logic        [CAW-1:0]      addr0;
    logic        [CAW-1:0]      addr1;
    logic        [CAW-1:0]      waddr;

    // stage 4: samples from store
    logic        [SAMPLE_W-1:0] y0_rd;
    logic        [SAMPLE_W-1:0] y1_rd;
    logic                       neg4_reg;
    logic        [23:0]         frac4_reg;
    logic                       zero4_reg;
    logic                       last4_reg;
    logic signed [16:0]         slope;
    logic signed [24:0]         sfrac;
    logic signed [41:0]         prod_next;

    // stage 5: truncated step
    logic signed [41:0]         prod5_reg;
    logic signed [SAMPLE_W-1:0] y05_reg;
    logic                       zero5_reg;
    logic                       last5_reg;
    logic signed [41:0]         prod_adj;
    logic signed [VAL_W-1:0]    step;
    logic signed [VAL_W-1:0]    val_next;

    // stage 6
    logic signed [VAL_W-1:0]    val_reg;

    always_comb
    begin
        diff     = 33'(item.delay) - 33'(cfg.start_time);
        mag_next = diff[32] ? 33'(-diff) : 33'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld2_reg <= 1'b0;
            ld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            ld2_reg <= ld_en;
            ld3_reg <= ld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg2_reg  <= diff[32];
            mag2_reg  <= mag_next;
            sidx2_reg <= item.sample_index;
            sval2_reg <= item.sample_value;

            hi3_reg   <= mag2_reg * cfg.recip_spacing[31:16];
            lo3_reg   <= mag2_reg * cfg.recip_spacing[15:0];
            neg3_reg  <= neg2_reg;
            sidx3_reg <= sidx2_reg;
            sval3_reg <= sval2_reg;
        end
    end

    // Position in Q.24; index above 24 bits, fraction below
    always_comb
    begin
        pos     = {1'b0, hi3_reg} + 50'(lo3_reg[48:16]);
        idx     = pos[49:24];
        idx32   = 32'(idx);
        npts32  = 32'(cfg.num_points);
        depth32 = 32'(CORR_DEPTH);
        n32     = (npts32 < depth32) ? npts32 : depth32;
        // negative offsets only interpolate within the first interval
        zero_next = (neg3_reg && (idx != '0)) || (idx32 >= n32);
        last_next = (idx32 + 32'd1) >= n32;
        addr0     = CAW'(idx);
        addr1     = CAW'(idx + 26'd1);
        waddr     = CAW'(sidx3_reg);
    end

    // Two copies of the store so both neighbours come out in one read
    ima_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (CORR_DEPTH)
    ) u_corr_lo (
        .clk   (clk),
        .we    (adv && ld3_reg),
        .waddr (waddr),
        .wdata (sval3_reg),
        .re    (adv),
        .raddr (addr0),
        .rdata (y0_rd)
    );

    ima_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (CORR_DEPTH)
    ) u_corr_hi (
        .clk   (clk),
        .we    (adv && ld3_reg),
        .waddr (waddr),
        .wdata (sval3_reg),
        .re    (adv),
        .raddr (addr1),
        .rdata (y1_rd)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg4_reg  <= neg3_reg;
            frac4_reg <= pos[23:0];
            zero4_reg <= zero_next;
            last4_reg <= last_next;
        end
    end

    always_comb
    begin
        slope     = $signed({y1_rd[SAMPLE_W-1], y1_rd}) - $signed({y0_rd[SAMPLE_W-1], y0_rd});
        sfrac     = neg4_reg ? -$signed({1'b0, frac4_reg}) : $signed({1'b0, frac4_reg});
        prod_next = slope * sfrac;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod5_reg <= prod_next;
            y05_reg   <= $signed(y0_rd);
            zero5_reg <= zero4_reg;
            last5_reg <= last4_reg;
        end
    end

    // divide by 2^24 rounding toward zero
    always_comb
    begin
        prod_adj = prod5_reg[41] ? (prod5_reg + 42'sd16777215) : prod5_reg;
        step     = prod_adj[41:24];
        if (zero5_reg)
        begin
            val_next = '0;
        end
        else if (last5_reg)
        begin
            val_next = VAL_W'(y05_reg);
        end
        else
        begin
            val_next = VAL_W'(y05_reg) + step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule
